@@ hdl/anmd_pkg.sv @@
// anmd_pkg: shared types and constants for the aml namestring decoder
// holds the phase encoding, the aml prefix byte values and the queue record
// no dependencies
package anmd_pkg;

	localparam int DATA_W          = 8;
	localparam int CFG_W           = 9;
	localparam int MAX_NAME_LENGTH = 256;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// aml prefix bytes
	localparam logic [7:0] NULL_NAME    = 8'h00;
	localparam logic [7:0] DOT_CHAR     = 8'h2E;
	localparam logic [7:0] DUAL_PREFIX  = 8'h2E;
	localparam logic [7:0] MULTI_PREFIX = 8'h2F;
	localparam logic [7:0] ROOT_CHAR    = 8'h5C;
	localparam logic [7:0] PARENT_CHAR  = 8'h5E;

	// index of the last byte of a four-byte name segment
	localparam logic [1:0] SEG_LAST = 2'd3;

	typedef enum logic [1:0] {
		PH_ROOT,
		PH_PARENT,
		PH_COUNT,
		PH_SEG
	} phase_t;

	// results caused by one input byte, at most two
	typedef struct packed {
		logic        two;   // two results: c0 then c1
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic        v0;    // c0 is a kept character (0 for a bare end marker)
		logic        done;  // last result of this record ends the name
	} rec_t;

	typedef struct packed {
		logic empty;
		logic full;
		rec_t head;
	} qstat_t;

endpackage

@@ hdl/anmd_front.sv @@
// anmd_front: accepts aml bytes, tracks the namestring phase and builds
// one result record per byte that yields output
// depends on anmd_pkg
module anmd_front #(
	parameter int MAX_NAME_LENGTH = anmd_pkg::MAX_NAME_LENGTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [anmd_pkg::DATA_W-1:0]  byte_in,
	input  logic [anmd_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         cfg_we,
	output logic                         push,
	output anmd_pkg::rec_t               rec
);

	localparam int CW = $clog2(MAX_NAME_LENGTH);
	localparam int LW = ($clog2(MAX_NAME_LENGTH + 1) > anmd_pkg::CFG_W) ?
		$clog2(MAX_NAME_LENGTH + 1) : anmd_pkg::CFG_W;
	localparam logic [LW-1:0] MAXL = LW'(MAX_NAME_LENGTH);

	logic [LW-1:0]     max_length_q;
	anmd_pkg::phase_t  phase_q, phase_n;
	logic [7:0]        sl_q, sl_n, sl_src;
	logic [1:0]        bis_q, bis_n, bis_src;
	logic              lat_q, lat_n, lat_src;
	logic [CW-1:0]     cw_q, cw_n;

	logic [LW-1:0]     cap, lim, cw_ext;
	logic              e0, e1, fin, do_seg, k0, k1;
	logic [7:0]        e0c, e1c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAXL;
		end else if (cfg_we) begin
			max_length_q <= LW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= anmd_pkg::PH_ROOT;
			sl_q    <= '0;
			bis_q   <= '0;
			lat_q   <= 1'b0;
			cw_q    <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			sl_q    <= sl_n;
			bis_q   <= bis_n;
			lat_q   <= lat_n;
			cw_q    <= cw_n;
		end
	end

	// capacity clamp and keep limit
	assign cap    = (max_length_q > MAXL) ? MAXL : max_length_q;
	assign lim    = (cap == '0) ? '0 : cap - LW'(1);
	assign cw_ext = LW'(cw_q);

	always_comb begin
		phase_n = phase_q;
		sl_n    = sl_q;
		bis_n   = bis_q;
		lat_n   = lat_q;
		sl_src  = sl_q;
		bis_src = bis_q;
		lat_src = lat_q;
		e0      = 1'b0;
		e1      = 1'b0;
		e0c     = byte_in;
		e1c     = byte_in;
		fin     = 1'b0;
		do_seg  = 1'b0;

		case (phase_q)
			anmd_pkg::PH_COUNT: begin
				if (byte_in == anmd_pkg::NULL_NAME) begin
					fin = 1'b1;
				end else begin
					sl_n    = byte_in;
					bis_n   = '0;
					lat_n   = 1'b0;
					phase_n = anmd_pkg::PH_SEG;
				end
			end
			anmd_pkg::PH_SEG: begin
				do_seg = 1'b1;
			end
			default: begin
				if (phase_q == anmd_pkg::PH_ROOT && byte_in == anmd_pkg::ROOT_CHAR) begin
					e0 = 1'b1;
				end else if (byte_in == anmd_pkg::PARENT_CHAR) begin
					e0      = 1'b1;
					phase_n = anmd_pkg::PH_PARENT;
				end else if (byte_in == anmd_pkg::NULL_NAME) begin
					fin = 1'b1;
				end else if (byte_in == anmd_pkg::DUAL_PREFIX) begin
					sl_n    = 8'd2;
					bis_n   = '0;
					lat_n   = 1'b0;
					phase_n = anmd_pkg::PH_SEG;
				end else if (byte_in == anmd_pkg::MULTI_PREFIX) begin
					phase_n = anmd_pkg::PH_COUNT;
				end else begin
					do_seg  = 1'b1;
					sl_src  = 8'd1;
					bis_src = '0;
					lat_src = 1'b0;
					phase_n = anmd_pkg::PH_SEG;
				end
			end
		endcase

		if (do_seg) begin
			if (bis_src == 2'd0 && lat_src) begin
				e0  = 1'b1;
				e0c = anmd_pkg::DOT_CHAR;
				e1  = 1'b1;
			end else begin
				e0 = 1'b1;
			end
			bis_n = bis_src + 2'd1;
			lat_n = lat_src;
			sl_n  = sl_src;
			if (bis_src == anmd_pkg::SEG_LAST) begin
				bis_n = '0;
				lat_n = 1'b1;
				sl_n  = sl_src - 8'd1;
				if (sl_src == 8'd1) begin
					fin = 1'b1;
				end
			end
		end

		// kept characters form a prefix of the candidates
		k0 = e0 && (cw_ext < lim);
		k1 = e1 && ((cw_ext + LW'(k0)) < lim);

		cw_n = cw_q + CW'(k0) + CW'(k1);

		if (fin) begin
			phase_n = anmd_pkg::PH_ROOT;
			sl_n    = '0;
			bis_n   = '0;
			lat_n   = 1'b0;
			cw_n    = '0;
		end

		push     = take && (k0 || fin);
		rec.two  = k0 && k1;
		rec.c0   = k0 ? e0c : 8'h00;
		rec.c1   = e1c;
		rec.v0   = k0;
		rec.done = fin;
	end

endmodule

@@ hdl/anmd_queue.sv @@
// anmd_queue: short record queue between front and back
// depends on anmd_pkg
module anmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  anmd_pkg::rec_t    wr_rec,
	input  logic              pop,
	output anmd_pkg::qstat_t  stat
);

	localparam int CNTW = anmd_pkg::QAW + 1;

	anmd_pkg::rec_t              mem_q [anmd_pkg::QDEPTH];
	logic [anmd_pkg::QAW-1:0]    wp_q, rp_q;
	logic [CNTW-1:0]             cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + anmd_pkg::QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + anmd_pkg::QAW'(1);
			end
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNTW'(anmd_pkg::QDEPTH));
	assign stat.head  = mem_q[rp_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(anmd_pkg::QDEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("push into full queue");

endmodule

@@ hdl/anmd_back.sv @@
// anmd_back: takes records from the queue and delivers their results
// one per cycle through the output register while m_tready is high
// depends on anmd_pkg
module anmd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  anmd_pkg::qstat_t  stat,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	logic       m_tvalid_q, sub_q, load;
	logic [7:0] m_tdata_q;
	logic       m_tuser_q, m_tlast_q;

	assign load = !m_tvalid_q || m_tready;
	assign pop  = load && !stat.empty && (!stat.head.two || sub_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			sub_q      <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= !stat.empty;
			if (!stat.empty) begin
				sub_q <= stat.head.two && !sub_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !stat.empty) begin
			if (sub_q) begin
				m_tdata_q <= stat.head.c1;
				m_tuser_q <= 1'b1;
				m_tlast_q <= stat.head.done;
			end else begin
				m_tdata_q <= stat.head.c0;
				m_tuser_q <= stat.head.v0;
				m_tlast_q <= stat.head.done && !stat.head.two;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_sub_has_rec: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> !stat.empty)
		else $error("second result pending without a queued record");

endmodule

@@ hdl/aml_namestring_decoder.sv @@
// aml_namestring_decoder: top level of the aml namestring decoder
// instantiates anmd_front, anmd_queue and anmd_back; depends on anmd_pkg
//
// usage
//   slave channel s_tvalid/s_tready/s_tdata carries the aml stream, one byte per
//   transfer. master channel m_tvalid/m_tready/m_tdata/m_tuser/m_tlast gives the
//   decoded name text one character per transfer: tuser high for a kept
//   character, low for a bare end marker (tdata zero); tlast marks the last
//   transfer of a namestring.
//   cfg_we/cfg_wdata write max_length, the output capacity including the
//   terminator; write it only while the block is idle.
// timing
//   the front decodes a byte in the cycle it is accepted and queues a record;
//   the first result then passes through the queue and the output register.
//   one byte is taken per cycle while the four-entry queue has room; the
//   master side gives one transfer per cycle while m_tready is high, so a byte
//   with a dot and a character needs two transfers, which sets the sustained rate.
// reset and stall
//   arst_n clears the phase, counters, queue and output register and sets
//   max_length to MAX_NAME_LENGTH. when the receiver stalls the output register
//   holds its transfer, the queue fills and s_tready drops once it is full.
module aml_namestring_decoder #(
	parameter int MAX_NAME_LENGTH = anmd_pkg::MAX_NAME_LENGTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// s_tdata: in_byte [7:0]
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [anmd_pkg::DATA_W-1:0] s_tdata,
	// m_tdata: out_char [7:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [anmd_pkg::DATA_W-1:0] m_tdata,
	// m_tuser: char_valid [0]
	output logic                        m_tuser,
	// m_tlast: name_done
	output logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic [anmd_pkg::CFG_W-1:0]  cfg_wdata
);

	logic              take, push, pop;
	anmd_pkg::rec_t    rec;
	anmd_pkg::qstat_t  stat;

	// room in the queue is all the front needs to take a byte
	assign s_tready = !stat.full;
	assign take     = s_tvalid && s_tready;

	anmd_front #(
		.MAX_NAME_LENGTH(MAX_NAME_LENGTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_in   (s_tdata),
		.cfg_wdata (cfg_wdata),
		.cfg_we    (cfg_we),
		.push      (push),
		.rec       (rec)
	);

	anmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (rec),
		.pop    (pop),
		.stat   (stat)
	);

	anmd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// a bare end marker always closes a name and carries a zero character
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
		else $error("bare end marker malformed");

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for the aml namestring decoder
// streams aml bytes in, predicts the dotted name text and checks each output transfer
// depends on anmd_pkg and aml_namestring_decoder
module testbench;

	localparam int HALF_PERIOD   = 5;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SHOW_LIMIT    = 10;
	localparam int PHASE_ITEMS   = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AT       = 6;
	localparam int HOLD_CYCLES   = 120;

	// one output transfer: character, kept flag (tuser), end of name (tlast)
	typedef struct packed {
		logic [7:0] ch;
		logic       kept;
		logic       last;
	} name_char_t;

	// one input byte; pinned rows carry their single result typed in
	typedef struct packed {
		logic [7:0] aml;
		logic       pinned;
		name_char_t res;
	} feed_t;

	localparam name_char_t END_MARK    = '{anmd_pkg::NULL_NAME, 1'b0, 1'b1};
	localparam name_char_t ROOT_KEPT   = '{anmd_pkg::ROOT_CHAR, 1'b1, 1'b0};
	localparam name_char_t PARENT_KEPT = '{anmd_pkg::PARENT_CHAR, 1'b1, 1'b0};
	localparam name_char_t NO_RES      = '0;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = '0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;
	logic       cfg_we    = 1'b0;
	logic [8:0] cfg_wdata = '0;

	aml_namestring_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------------
	// decoder predictor: own copy of the capacity register and name state
	// ---------------------------------------------------------------------
	logic [8:0]        name_cap   = 9'(anmd_pkg::MAX_NAME_LENGTH);
	anmd_pkg::phase_t  dec_phase  = anmd_pkg::PH_ROOT;
	logic [7:0]        segs_left  = '0;
	logic [1:0]        seg_pos    = '0;
	logic              later_seg  = 1'b0;
	logic [7:0]        chars_kept = '0;

	name_char_t step_out[$];     // transfers caused by the byte just decoded
	name_char_t name_text_q[$];  // transfers still awaited on the master side
	feed_t      feed_q[$];       // bytes still to be offered on the slave side

	int  items_sent   = 0;
	int  results_seen = 0;
	int  fail_count   = 0;
	bit  s_burst      = 1'b0;
	bit  m_burst      = 1'b0;

	// run guard: a hang anywhere ends the run as a failure
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transfers still awaited",
				cycles, name_text_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// characters kept while the count stays below capacity minus the terminator
	function automatic int keep_limit();
		int cap;
		cap = (name_cap > anmd_pkg::MAX_NAME_LENGTH) ?
			anmd_pkg::MAX_NAME_LENGTH : int'(name_cap);
		return (cap == 0) ? 0 : cap - 1;
	endfunction

	function automatic void keep_char(logic [7:0] ch);
		if (int'(chars_kept) < keep_limit()) begin
			step_out.push_back('{ch, 1'b1, 1'b0});
			chars_kept++;
		end
	endfunction

	// end of name: tlast on the last kept character, or a bare end marker
	function automatic void close_name();
		if (step_out.size() > 0) begin
			step_out[step_out.size() - 1].last = 1'b1;
		end else begin
			step_out.push_back(END_MARK);
		end
		dec_phase  = anmd_pkg::PH_ROOT;
		segs_left  = '0;
		seg_pos    = '0;
		later_seg  = 1'b0;
		chars_kept = '0;
	endfunction

	function automatic void start_segments(logic [7:0] count);
		segs_left = count;
		seg_pos   = '0;
		later_seg = 1'b0;
		dec_phase = anmd_pkg::PH_SEG;
	endfunction

	// a dot goes in front of every segment but the first
	function automatic void take_seg_byte(logic [7:0] b);
		if (seg_pos == '0 && later_seg) keep_char(anmd_pkg::DOT_CHAR);
		keep_char(b);
		if (seg_pos == anmd_pkg::SEG_LAST) begin
			seg_pos   = '0;
			later_seg = 1'b1;
			segs_left = segs_left - 8'd1;
			if (segs_left == '0) close_name();
		end else begin
			seg_pos = seg_pos + 2'd1;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		step_out.delete();
		case (dec_phase)
			anmd_pkg::PH_COUNT: begin
				// a zero segment count ends the name at once
				if (b == anmd_pkg::NULL_NAME) close_name();
				else start_segments(b);
			end
			anmd_pkg::PH_SEG: begin
				take_seg_byte(b);
			end
			default: begin
				// a root after a parent prefix falls through to a segment byte
				if (dec_phase == anmd_pkg::PH_ROOT && b == anmd_pkg::ROOT_CHAR) begin
					keep_char(b);
				end else if (b == anmd_pkg::PARENT_CHAR) begin
					keep_char(b);
					dec_phase = anmd_pkg::PH_PARENT;
				end else if (b == anmd_pkg::NULL_NAME) begin
					close_name();
				end else if (b == anmd_pkg::DUAL_PREFIX) begin
					start_segments(8'd2);
				end else if (b == anmd_pkg::MULTI_PREFIX) begin
					dec_phase = anmd_pkg::PH_COUNT;
				end else begin
					start_segments(8'd1);
					take_seg_byte(b);
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// directed opening, decoded from reset with the default capacity
	// ---------------------------------------------------------------------
	localparam int OPENING_ROWS = 26;
	feed_t opening [OPENING_ROWS] = '{
		'{anmd_pkg::NULL_NAME,    1'b1, END_MARK},     // null name, nothing kept
		'{anmd_pkg::ROOT_CHAR,    1'b1, ROOT_KEPT},
		'{anmd_pkg::ROOT_CHAR,    1'b1, ROOT_KEPT},
		'{anmd_pkg::PARENT_CHAR,  1'b1, PARENT_KEPT},
		'{anmd_pkg::ROOT_CHAR,    1'b1, ROOT_KEPT},    // root after parent opens a segment
		'{8'h41,                  1'b0, NO_RES},
		'{8'h5F,                  1'b0, NO_RES},
		'{8'hFF,                  1'b0, NO_RES},       // closes the single segment
		'{anmd_pkg::DUAL_PREFIX,  1'b0, NO_RES},
		'{8'h00,                  1'b0, NO_RES},       // prefix codes as plain segment bytes
		'{8'h80,                  1'b0, NO_RES},
		'{8'h7F,                  1'b0, NO_RES},
		'{8'h01,                  1'b0, NO_RES},
		'{anmd_pkg::DUAL_PREFIX,  1'b0, NO_RES},       // dot and character in one byte
		'{anmd_pkg::MULTI_PREFIX, 1'b0, NO_RES},
		'{anmd_pkg::ROOT_CHAR,    1'b0, NO_RES},
		'{anmd_pkg::PARENT_CHAR,  1'b0, NO_RES},
		'{anmd_pkg::MULTI_PREFIX, 1'b0, NO_RES},
		'{anmd_pkg::NULL_NAME,    1'b1, END_MARK},     // multi count of zero
		'{anmd_pkg::PARENT_CHAR,  1'b1, PARENT_KEPT},
		'{anmd_pkg::MULTI_PREFIX, 1'b0, NO_RES},
		'{8'h01,                  1'b0, NO_RES},
		'{8'h5F,                  1'b0, NO_RES},
		'{8'h58,                  1'b0, NO_RES},
		'{8'h59,                  1'b0, NO_RES},
		'{8'h31,                  1'b0, NO_RES}
	};

	// ---------------------------------------------------------------------
	// random names: mostly well formed, some noise and truncated names
	// ---------------------------------------------------------------------
	function automatic logic [7:0] lead_char();
		return ($urandom_range(0, 7) == 0) ? 8'h5F : 8'($urandom_range(8'h41, 8'h5A));
	endfunction

	function automatic logic [7:0] body_char();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(0, 255));
			1:       return 8'($urandom_range(8'h30, 8'h39));
			default: return lead_char();
		endcase
	endfunction

	function automatic void push_byte(logic [7:0] b);
		feed_q.push_back('{b, 1'b0, NO_RES});
	endfunction

	function automatic void add_random_name();
		int         nsegs;
		int         nbytes;
		logic [7:0] count;
		if ($urandom_range(0, 6) == 0) begin
			push_byte(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) push_byte(anmd_pkg::ROOT_CHAR);
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) push_byte(anmd_pkg::PARENT_CHAR);
		case ($urandom_range(0, 9))
			0: begin
				push_byte(anmd_pkg::NULL_NAME);
				return;
			end
			1, 2, 3: begin
				push_byte(lead_char());
				nsegs  = 1;
				nbytes = 3;
			end
			4, 5, 6: begin
				push_byte(anmd_pkg::DUAL_PREFIX);
				nsegs  = 2;
				nbytes = 8;
			end
			default: begin
				count = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
				push_byte(anmd_pkg::MULTI_PREFIX);
				push_byte(count);
				nsegs  = int'(count);
				nbytes = 4 * nsegs;
			end
		endcase
		// a broken name leaves the decoder mid-segment for the next one
		if (nbytes > 0 && $urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nbytes - 1);
		repeat (nbytes) push_byte(body_char());
	endfunction

	// ---------------------------------------------------------------------
	// slave side: offer queued bytes, predict each accepted transfer
	// ---------------------------------------------------------------------
	task automatic stream_feed();
		int    gap;
		feed_t row;
		while (feed_q.size() != 0) begin
			if ($urandom_range(0, 11) == 0) s_burst = !s_burst;
			gap = s_burst ? 0 : $urandom_range(0, 16);
			row = feed_q.pop_front();
			// valid only drops when a gap follows, never low and high in one step
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= row.aml;
			do @(posedge clk); while (!s_tready);
			decode_byte(row.aml);
			if (row.pinned) begin
				name_text_q.push_back(row.res);
			end else begin
				foreach (step_out[i]) name_text_q.push_back(step_out[i]);
			end
			items_sent++;
		end
		s_tvalid <= 1'b0;
	endtask

	// capacity is only changed once the decoder has drained
	task automatic set_capacity(logic [8:0] cap);
		while (name_text_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
		name_cap   = cap;
	endtask

	// ---------------------------------------------------------------------
	// master side: random back-pressure, one long hold-off, field checks
	// ---------------------------------------------------------------------
	task automatic check_transfer(name_char_t got);
		name_char_t want;
		results_seen++;
		if (name_text_q.size() == 0) begin
			fail_count++;
			if (fail_count <= SHOW_LIMIT)
				$display("unexpected transfer: char %h kept %b last %b",
					got.ch, got.kept, got.last);
			return;
		end
		want = name_text_q.pop_front();
		if (got.ch !== want.ch || got.kept !== want.kept || got.last !== want.last) begin
			fail_count++;
			if (fail_count <= SHOW_LIMIT)
				$display("transfer %0d: expected char %h kept %b last %b, got %h %b %b",
					results_seen, want.ch, want.kept, want.last,
					got.ch, got.kept, got.last);
		end
	endtask

	initial begin : drain_side
		int gap;
		bit held = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 11) == 0) m_burst = !m_burst;
			gap = m_burst ? 0 : $urandom_range(0, 16);
			// one long stall so the internal queue fills and s_tready drops
			if (!held && results_seen >= HOLD_AT) begin
				gap  = HOLD_CYCLES;
				held = 1'b1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_transfer('{m_tdata, m_tuser, m_tlast});
		end
	end

	// ---------------------------------------------------------------------
	// run sequence: reset, directed opening, random names per capacity
	// ---------------------------------------------------------------------
	initial begin : run
		logic [8:0] caps [8];
		caps = '{9'd2, 9'd1, 9'd0, 9'd511, 9'd5, 9'($urandom_range(3, 255)), 9'd300, 9'd256};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) feed_q.push_back(opening[i]);
		stream_feed();

		foreach (caps[k]) begin
			set_capacity(caps[k]);
			while (feed_q.size() < PHASE_ITEMS) add_random_name();
			stream_feed();
		end

		while (name_text_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		fail_count += name_text_q.size();

		$display("%0d aml bytes decoded into %0d output transfers, 9 capacity settings",
			items_sent, results_seen);
		$display("%0d failing transfers", fail_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
